// File: rtl/bwa_pkg.sv
// Shared types, constants and fixed-point helpers for the Breit-Wigner amplitude block
`default_nettype none
package bwa_pkg;

   localparam int FRAC_BITS = 24;
   localparam int Q_W       = 32;   // width of every Q8.24 value
   localparam int CFG_W     = 31;   // width of the resonance registers
   localparam int CSR_IDX_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RESONANCE_MASS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_RESONANCE_WIDTH = 1'b1;

   localparam logic [CFG_W-1:0] MASS_RESET  = 31'd16777216;
   localparam logic [CFG_W-1:0] WIDTH_RESET = 31'd1677722;

   // divider geometry
   localparam int DIV_NUM_W = 56;   // |a| << 24, |a| <= 2^31
   localparam int DIV_DEN_W = 32;
   localparam int LG_NUM_W  = 45;   // |32 * poly| < 2^45

   // divide by 63 as a reciprocal multiply: product width and final shift
   localparam int LG_PROD_W = 96;
   localparam int LG_SHIFT  = 51;

   // Legendre coefficients
   localparam logic signed [47:0] C_SIXTY_THREE = 48'sd63;
   localparam logic signed [47:0] C_SEVENTY     = 48'sd70;
   localparam logic signed [47:0] C_FIFTEEN     = 48'sd15;
   localparam int                 C_SHIFT_32    = 5;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic              sat;
      logic signed [31:0] val;
   } qres_type;

   // pipeline record, fields are reused as the work moves on
   typedef struct packed {
      logic               sat;
      logic signed [31:0] m;
      logic signed [31:0] s;
      logic signed [31:0] ff;
      logic signed [31:0] g;
      logic signed [31:0] msq;
      logic signed [31:0] d;    // m*m, then D, then real part
      logic signed [31:0] x2;
      logic signed [31:0] x3;
      logic signed [31:0] x5;
      logic signed [31:0] dd;
      logic signed [31:0] r;    // M/m
      logic signed [47:0] n;    // -32 * poly
      logic signed [31:0] lg;
      logic signed [31:0] t;    // M^2*G, then M^2*G*G, then den
      logic signed [31:0] mg;   // M*G, then imaginary part
      logic signed [31:0] sc;
   } bwa_bundle_type;

   function automatic qres_type clamp_q(input logic signed [63:0] v);
      qres_type r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r.sat = 1'b1;
         r.val = Q_MAX;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r.sat = 1'b1;
         r.val = Q_MIN;
      end else begin
         r.sat = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

   // round to nearest, ties toward plus infinity
   function automatic qres_type qmul(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      p = (p + 64'sd8388608) >>> FRAC_BITS;
      return clamp_q(p);
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      return a[31] ? 32'(-a) : 32'(a);
   endfunction

   // sign, zero divisor and clamp for a quotient magnitude
   function automatic qres_type qdiv_fin(input logic a_neg, input logic b_zero,
                                         input logic neg, input logic ovf,
                                         input logic [31:0] q);
      logic [32:0] qq;
      qres_type    r;
      qq = (ovf || q > 32'h8000_0000) ? 33'h0_8000_0000 : {1'b0, q};
      if (b_zero) begin
         r.sat = 1'b1;
         r.val = a_neg ? Q_MIN : Q_MAX;
      end else if (neg) begin
         r.sat = 1'b0;
         r.val = 32'(33'd0 - qq);
      end else if (qq > 33'h0_7FFF_FFFF) begin
         r.sat = 1'b1;
         r.val = Q_MAX;
      end else begin
         r.sat = 1'b0;
         r.val = qq[31:0];
      end
      return r;
   endfunction

   function automatic qres_type lg_fin(input logic neg, input logic ovf,
                                       input logic [31:0] q);
      logic signed [63:0] v;
      qres_type           r;
      v = $signed({32'd0, q});
      if (ovf) begin
         r.sat = 1'b1;
         r.val = neg ? Q_MIN : Q_MAX;
      end else begin
         r = clamp_q(neg ? -v : v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/bwa_if.sv
// Request and response channel interfaces of the Breit-Wigner amplitude block
`default_nettype none
interface bwa_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] event_mass;
   logic signed [31:0] momentum_term;
   logic signed [31:0] ratio_parent;
   logic signed [31:0] ratio_resonance;
   logic signed [31:0] spin_value;
   modport source (output valid, event_mass, momentum_term, ratio_parent,
                   ratio_resonance, spin_value, input ready);
   modport sink (input valid, event_mass, momentum_term, ratio_parent,
                 ratio_resonance, spin_value, output ready);
endinterface

interface bwa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] amp_real;
   logic signed [31:0] amp_imag;
   logic               saturated;
   modport source (output valid, amp_real, amp_imag, saturated, input ready);
   modport sink (input valid, amp_real, amp_imag, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/breit_wigner_amplitude.sv
// Top level of the relativistic Breit-Wigner amplitude pipeline
// Takes one event per cycle and returns one amplitude per event, in order.
// The pipeline is twelve arithmetic stages (mostly 32x32 multiplies),
// two 32-stage restoring dividers (M/m and s/den), each producing one
// quotient bit per stage, and a two-stage reciprocal multiply for the
// Legendre /63. When the response is held off the whole pipeline stalls in
// place; with the response side ready the block sustains one transfer per
// cycle on both channels.
`default_nettype none
module breit_wigner_amplitude
   import bwa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bwa_req_if.sink              req_if,
   bwa_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);
   localparam int NUM_STG = 12;
   localparam int BW      = $bits(bwa_bundle_type);

   // configuration
   logic [CFG_W-1:0] mass_ff, mass_in;
   logic [CFG_W-1:0] width_ff, width_in;

   always_comb begin
      mass_in  = mass_ff;
      width_in = width_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RESONANCE_MASS:  mass_in  = csr_wdata;
            REG_RESONANCE_WIDTH: width_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff  <= MASS_RESET;
         width_ff <= WIDTH_RESET;
      end else begin
         mass_ff  <= mass_in;
         width_ff <= width_in;
      end
   end

   logic signed [31:0] mass_s, width_s;
   assign mass_s  = $signed({1'b0, mass_ff});
   assign width_s = $signed({1'b0, width_ff});

   // stage registers
   bwa_bundle_type stg_ff [NUM_STG];
   bwa_bundle_type stg_in [NUM_STG];
   logic           v_ff   [NUM_STG];
   logic           v_in   [NUM_STG];
   logic           en;

   assign en           = !v_ff[NUM_STG-1] || rsp_if.ready;
   assign req_if.ready = en;

   // dividers
   logic              d1_v, d2_v, d3_v;
   logic [Q_W-1:0]    d1_q, d2_q, d3_q;
   logic              d1_o, d2_o, d3_o;
   logic [BW-1:0]     d1_p, d3_p;
   bwa_bundle_type    d1_b, d2_b, d3_b;
   logic [LG_NUM_W-1:0] lg_num;

   assign d1_b = bwa_bundle_type'(d1_p);
   assign d3_b = bwa_bundle_type'(d3_p);
   assign lg_num = stg_ff[3].n[47] ? LG_NUM_W'(-stg_ff[3].n) : LG_NUM_W'(stg_ff[3].n);

   // M / m
   bwa_div #(.NW(DIV_NUM_W), .DW(DIV_DEN_W), .QW(Q_W), .PW(BW)) u_div_mass (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v_ff[1]),
      .num      (DIV_NUM_W'(mass_ff) << FRAC_BITS),
      .den      (mag32(stg_ff[1].m)),
      .in_data  (BW'(stg_ff[1])),
      .out_valid(d1_v),
      .quo      (d1_q),
      .ovf      (d1_o),
      .out_data (d1_p)
   );

   // |-32 * poly| / 63: multiply by 2^45 + 2^39 + ... + 2^3 + 1 = ceil(2^51 / 63) and
   // keep bits from 51 up; exact for every numerator below 2^45
   logic [LG_PROD_W-1:0] lg_x;
   logic [LG_PROD_W-1:0] lg_s0_ff, lg_s1_ff, lg_s2_ff, lg_sum_ff;
   logic [LG_PROD_W-1:0] lg_s0_in, lg_s1_in, lg_s2_in, lg_sum_in;
   logic                 lg_v0_ff, lg_v1_ff;
   bwa_bundle_type       lg_b0_ff, lg_b1_ff;

   assign lg_x      = LG_PROD_W'(lg_num);
   assign lg_s0_in  = (lg_x << 45) + (lg_x << 39) + (lg_x << 33);
   assign lg_s1_in  = (lg_x << 27) + (lg_x << 21) + (lg_x << 15);
   assign lg_s2_in  = (lg_x << 9) + (lg_x << 3) + lg_x;
   assign lg_sum_in = lg_s0_ff + lg_s1_ff + lg_s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_v0_ff <= 1'b0;
         lg_v1_ff <= 1'b0;
      end else if (en) begin
         lg_v0_ff <= v_ff[3];
         lg_v1_ff <= lg_v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lg_s0_ff  <= lg_s0_in;
         lg_s1_ff  <= lg_s1_in;
         lg_s2_ff  <= lg_s2_in;
         lg_sum_ff <= lg_sum_in;
         lg_b0_ff  <= stg_ff[3];
         lg_b1_ff  <= lg_b0_ff;
      end
   end

   assign d2_v = lg_v1_ff;
   assign d2_q = lg_sum_ff[LG_SHIFT +: Q_W];
   assign d2_o = |lg_sum_ff[LG_PROD_W-1:LG_SHIFT+Q_W];
   assign d2_b = lg_b1_ff;

   // s / den
   bwa_div #(.NW(DIV_NUM_W), .DW(DIV_DEN_W), .QW(Q_W), .PW(BW)) u_div_den (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v_ff[7]),
      .num      (DIV_NUM_W'(mag32(stg_ff[7].s)) << FRAC_BITS),
      .den      (mag32(stg_ff[7].t)),
      .in_data  (BW'(stg_ff[7])),
      .out_valid(d3_v),
      .quo      (d3_q),
      .ovf      (d3_o),
      .out_data (d3_p)
   );

   // valid chain
   always_comb begin
      for (int i = 0; i < NUM_STG; i++) begin
         case (i)
            0:       v_in[i] = req_if.valid;
            2:       v_in[i] = d1_v;
            4:       v_in[i] = d2_v;
            8:       v_in[i] = d3_v;
            default: v_in[i] = v_ff[(i == 0) ? 0 : i - 1];
         endcase
      end
   end

   // stage arithmetic
   always_comb begin : p_stages
      qres_type a, b, c, e, f;
      logic signed [47:0] poly;

      // 0: ff, W*q, M*M, m*m, s*s
      a = qmul(req_if.ratio_parent, req_if.ratio_resonance);
      b = qmul(width_s, req_if.momentum_term);
      c = qmul(mass_s, mass_s);
      e = qmul(req_if.event_mass, req_if.event_mass);
      f = qmul(req_if.spin_value, req_if.spin_value);
      stg_in[0]     = '0;
      stg_in[0].m   = req_if.event_mass;
      stg_in[0].s   = req_if.spin_value;
      stg_in[0].ff  = a.val;
      stg_in[0].g   = b.val;
      stg_in[0].msq = c.val;
      stg_in[0].d   = e.val;
      stg_in[0].x2  = f.val;
      stg_in[0].sat = a.sat | b.sat | c.sat | e.sat | f.sat;

      // 1: D = M^2 - m^2, x^3
      stg_in[1] = stg_ff[0];
      a = clamp_q(64'(stg_ff[0].msq) - 64'(stg_ff[0].d));
      b = qmul(stg_ff[0].x2, stg_ff[0].s);
      stg_in[1].d   = a.val;
      stg_in[1].x3  = b.val;
      stg_in[1].sat = stg_ff[0].sat | a.sat | b.sat;

      // 2: finish M/m, x^5, D*D
      stg_in[2] = d1_b;
      a = qdiv_fin(1'b0, d1_b.m == 32'sd0, d1_b.m[31], d1_o, d1_q);
      b = qmul(d1_b.x3, d1_b.x2);
      c = qmul(d1_b.d, d1_b.d);
      stg_in[2].r   = a.val;
      stg_in[2].x5  = b.val;
      stg_in[2].dd  = c.val;
      stg_in[2].sat = d1_b.sat | a.sat | b.sat | c.sat;

      // 3: G *= M/m, Legendre numerator
      stg_in[3] = stg_ff[2];
      a = qmul(stg_ff[2].g, stg_ff[2].r);
      poly = 48'(stg_ff[2].x5) * C_SIXTY_THREE - 48'(stg_ff[2].x3) * C_SEVENTY
           + 48'(stg_ff[2].s) * C_FIFTEEN;
      stg_in[3].g   = a.val;
      stg_in[3].n   = -(poly <<< C_SHIFT_32);
      stg_in[3].sat = stg_ff[2].sat | a.sat;

      // 4: finish L(s), G *= ff
      stg_in[4] = d2_b;
      a = lg_fin(d2_b.n[47], d2_o, d2_q);
      b = qmul(d2_b.g, d2_b.ff);
      stg_in[4].lg  = a.val;
      stg_in[4].g   = b.val;
      stg_in[4].sat = d2_b.sat | a.sat | b.sat;

      // 5: M^2*G, M*G
      stg_in[5] = stg_ff[4];
      a = qmul(stg_ff[4].msq, stg_ff[4].g);
      b = qmul(mass_s, stg_ff[4].g);
      stg_in[5].t   = a.val;
      stg_in[5].mg  = b.val;
      stg_in[5].sat = stg_ff[4].sat | a.sat | b.sat;

      // 6: M^2*G*G
      stg_in[6] = stg_ff[5];
      a = qmul(stg_ff[5].t, stg_ff[5].g);
      stg_in[6].t   = a.val;
      stg_in[6].sat = stg_ff[5].sat | a.sat;

      // 7: den
      stg_in[7] = stg_ff[6];
      a = clamp_q(64'(stg_ff[6].dd) + 64'(stg_ff[6].t));
      stg_in[7].t   = a.val;
      stg_in[7].sat = stg_ff[6].sat | a.sat;

      // 8: finish s/den
      stg_in[8] = d3_b;
      a = qdiv_fin(d3_b.s[31], d3_b.t == 32'sd0, d3_b.s[31] ^ d3_b.t[31], d3_o, d3_q);
      stg_in[8].sc  = a.val;
      stg_in[8].sat = d3_b.sat | a.sat;

      // 9: sc *= ff
      stg_in[9] = stg_ff[8];
      a = qmul(stg_ff[8].sc, stg_ff[8].ff);
      stg_in[9].sc  = a.val;
      stg_in[9].sat = stg_ff[8].sat | a.sat;

      // 10: sc *= L
      stg_in[10] = stg_ff[9];
      a = qmul(stg_ff[9].sc, stg_ff[9].lg);
      stg_in[10].sc  = a.val;
      stg_in[10].sat = stg_ff[9].sat | a.sat;

      // 11: real and imaginary parts
      stg_in[11] = stg_ff[10];
      a = qmul(stg_ff[10].d, stg_ff[10].sc);
      b = qmul(stg_ff[10].mg, stg_ff[10].sc);
      stg_in[11].d   = a.val;
      stg_in[11].mg  = b.val;
      stg_in[11].sat = stg_ff[10].sat | a.sat | b.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STG; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < NUM_STG; i++) v_ff[i] <= v_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_STG; i++) stg_ff[i] <= stg_in[i];
      end
   end

   assign rsp_if.valid     = v_ff[NUM_STG-1];
   assign rsp_if.amp_real  = stg_ff[NUM_STG-1].d;
   assign rsp_if.amp_imag  = stg_ff[NUM_STG-1].mg;
   assign rsp_if.saturated = stg_ff[NUM_STG-1].sat;

endmodule
`default_nettype wire

// File: rtl/bwa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload
`default_nettype none
module bwa_div
   import bwa_pkg::*;
#(
   parameter int NW = DIV_NUM_W,
   parameter int DW = DIV_DEN_W,
   parameter int QW = Q_W,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [PW-1:0] in_data,
   output logic          out_valid,
   output logic [QW-1:0] quo,
   output logic          ovf,
   output logic [PW-1:0] out_data
);
   localparam int CW = (NW > DW) ? NW : DW;

   logic          ovf0;
   logic [DW-1:0] rem0;

   // quotient would need more than QW bits
   assign ovf0 = CW'(num >> QW) >= CW'(den);
   assign rem0 = ovf0 ? '0 : DW'(num >> QW);

   logic          v_ff    [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] lo_ff   [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic          ovf_ff  [QW];
   logic [PW-1:0] data_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          sv;
      logic [DW-1:0] srem;
      logic [DW-1:0] sden;
      logic [QW-1:0] slo;
      logic [QW-1:0] squo;
      logic          sovf;
      logic [PW-1:0] sdata;
      logic [DW:0]   trial;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign sv    = in_valid;
         assign srem  = rem0;
         assign sden  = den;
         assign slo   = num[QW-1:0];
         assign squo  = '0;
         assign sovf  = ovf0;
         assign sdata = in_data;
      end else begin : g_next
         assign sv    = v_ff[k-1];
         assign srem  = rem_ff[k-1];
         assign sden  = den_ff[k-1];
         assign slo   = lo_ff[k-1];
         assign squo  = quo_ff[k-1];
         assign sovf  = ovf_ff[k-1];
         assign sdata = data_ff[k-1];
      end

      assign trial = {srem, slo[QW-1-k]};
      assign take  = trial >= {1'b0, sden};

      always_comb begin
         rem_in = take ? DW'(trial - {1'b0, sden}) : DW'(trial);
         quo_in = squo;
         quo_in[QW-1-k] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= sv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= sden;
            lo_ff[k]   <= slo;
            quo_ff[k]  <= quo_in;
            ovf_ff[k]  <= sovf;
            data_ff[k] <= sdata;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign quo       = quo_ff[QW-1];
   assign ovf       = ovf_ff[QW-1];
   assign out_data  = data_ff[QW-1];

endmodule
`default_nettype wire

// File: bench/breit_wigner_amplitude_test.sv
// Testbench for the Breit-Wigner amplitude pipeline: directed table plus random events
`timescale 1ns / 100ps
`default_nettype none
module breit_wigner_amplitude_test
   import bwa_pkg::*;
();

   typedef struct {
      logic signed [31:0] m, q, fp, fr, s;
   } event_type;

   typedef struct {
      logic signed [31:0] re, im;
      logic               sat;
   } amp_type;

   // directed row: event, whether an expected amplitude is typed in, and that amplitude
   typedef struct {
      event_type ev;
      bit        fixed;
      amp_type   amp;
   } dir_row_type;

   localparam int LATENCY     = 78;
   localparam int CYCLE_LIMIT = 900000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_RESONANCE_MASS;
   logic [CFG_W-1:0] csr_wdata = '0;

   bwa_req_if req_if ();
   bwa_rsp_if rsp_if ();

   breit_wigner_amplitude dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic signed [63:0] res_mass, res_width;
   amp_type expected_amps[$];
   int   errors = 0;
   int   cycles = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_off = 0;

   // ---------------- predictor ----------------
   function automatic logic signed [63:0] sat64(input logic signed [63:0] v, inout bit f);
      if (v > 64'sd2147483647) begin
         f = 1; return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         f = 1; return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b, inout bit f);
      logic signed [63:0] p;
      p = a * b + 64'sd8388608;
      return sat64(p >>> 24, f);
   endfunction

   function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
                                                  input logic signed [63:0] b, inout bit f);
      logic [63:0] ua, ub, qt;
      bit neg;
      if (b == 0) begin
         f = 1; return a < 0 ? -64'sd2147483648 : 64'sd2147483647;
      end
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      qt = (ua << 24) / ub;
      if (qt > 64'd2147483648) qt = 64'd2147483648;
      return sat64(neg ? -$signed(qt) : $signed(qt), f);
   endfunction

   function automatic logic signed [63:0] spin_factor(input logic signed [63:0] x, inout bit f);
      logic signed [63:0] x2, x3, x5, poly;
      x2 = fx_mul(x, x, f);
      x3 = fx_mul(x2, x, f);
      x5 = fx_mul(x3, x2, f);
      poly = 63 * x5 - 70 * x3 + 15 * x;
      return sat64((-32 * poly) / 63, f);
   endfunction

   function automatic amp_type predict_amplitude(input event_type e);
      bit f;
      logic signed [63:0] ff, g, msq, d, den, sc, mm;
      amp_type r;
      f = 0;
      ff = fx_mul(64'(e.fp), 64'(e.fr), f);
      g = fx_mul(res_width, 64'(e.q), f);
      g = fx_mul(g, fx_div(res_mass, 64'(e.m), f), f);
      g = fx_mul(g, ff, f);
      msq = fx_mul(res_mass, res_mass, f);
      mm = fx_mul(64'(e.m), 64'(e.m), f);
      d = sat64(msq - mm, f);
      den = sat64(fx_mul(d, d, f) + fx_mul(fx_mul(msq, g, f), g, f), f);
      sc = fx_div(64'(e.s), den, f);
      sc = fx_mul(sc, ff, f);
      sc = fx_mul(sc, spin_factor(64'(e.s), f), f);
      r.re = 32'(fx_mul(d, sc, f));
      r.im = 32'(fx_mul(fx_mul(res_mass, g, f), sc, f));
      r.sat = f;
      return r;
   endfunction

   // ---------------- driving ----------------
   initial begin
      req_if.valid = 1'b0;
      req_if.event_mass = '0;
      req_if.momentum_term = '0;
      req_if.ratio_parent = '0;
      req_if.ratio_resonance = '0;
      req_if.spin_value = '0;
      rsp_if.ready = 1'b0;
   end

   task automatic send_event(input event_type e);
      // valid drops only while the sender idles
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.event_mass <= e.m;
      req_if.momentum_term <= e.q;
      req_if.ratio_parent <= e.fp;
      req_if.ratio_resonance <= e.fr;
      req_if.spin_value <= e.s;
      do @(posedge clock); while (!req_if.ready);
      expected_amps.insert(expected_amps.size(), predict_amplitude(e));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_RESONANCE_MASS) res_mass = 64'(val);
      else res_width = 64'(val);
      @(posedge clock);
   endtask

   task automatic drain;
      while (expected_amps.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rnd_q();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $signed($urandom_range(33554432)) - 32'sd16777216;
         2: return $signed($urandom_range(100663296));
         3: return $signed($urandom_range(8388608)) - 32'sd4194304;
         4: return '0;
         default: return $signed($urandom_range(50331648)) - 32'sd25165824;
      endcase
   endfunction

   function automatic event_type rnd_event();
      event_type e;
      e.m = rnd_q(); e.q = rnd_q(); e.fp = rnd_q(); e.fr = rnd_q(); e.s = rnd_q();
      return e;
   endfunction

   // ---------------- receiving and checking ----------------
   always @(posedge clock) begin
      amp_type exp_a;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_amps.size() == 0) begin
               $error("unexpected transfer re=%h im=%h", rsp_if.amp_real, rsp_if.amp_imag);
               errors++;
            end else begin
               exp_a = expected_amps.pop_front();
               if (rsp_if.amp_real !== exp_a.re) begin
                  $error("amp_real exp %h got %h", exp_a.re, rsp_if.amp_real);
                  errors++;
               end
               if (rsp_if.amp_imag !== exp_a.im) begin
                  $error("amp_imag exp %h got %h", exp_a.im, rsp_if.amp_imag);
                  errors++;
               end
               if (rsp_if.saturated !== exp_a.sat) begin
                  $error("saturated exp %b got %b", exp_a.sat, rsp_if.saturated);
                  errors++;
               end
            end
         end
         if (hold_off > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off <= hold_off - 1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------- main sequence ----------------
   localparam logic signed [31:0] ONE = 32'sh0100_0000;
   localparam logic signed [31:0] QMX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] QMN = 32'sh8000_0000;

   dir_row_type dir_rows[$];

   function automatic dir_row_type mk(input logic signed [31:0] m, q, fp, fr, s,
                                      input bit fixed = 0,
                                      input logic signed [31:0] re = 0, im = 0,
                                      input logic sat = 0);
      dir_row_type r;
      r.ev.m = m; r.ev.q = q; r.ev.fp = fp; r.ev.fr = fr; r.ev.s = s;
      r.fixed = fixed; r.amp.re = re; r.amp.im = im; r.amp.sat = sat;
      return r;
   endfunction

   task automatic add_row(input dir_row_type r);
      dir_rows.insert(dir_rows.size(), r);
   endtask

   initial begin
      event_type e;
      amp_type   a;
      res_mass = 64'(MASS_RESET);
      res_width = 64'(WIDTH_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero event: zero mass, den = M^4, s = 0 -> zero amplitude, flag from M/0
      add_row(mk(0, 0, 0, 0, 0, 1, 0, 0, 1));
      // m = M, s = 0: den = 0 and s >= 0 saturates; product is zero via ff = 0
      add_row(mk(ONE, ONE, 0, 0, 0, 1, 0, 0, 1));
      // spin zero, everything else ordinary: no saturation, zero output
      add_row(mk(ONE * 2, ONE, ONE, ONE, 0, 1, 0, 0, 0));
      add_row(mk(ONE, ONE, ONE, ONE, -ONE));       // zero D, negative s
      add_row(mk(QMX, QMX, QMX, QMX, QMX));
      add_row(mk(QMN, QMN, QMN, QMN, QMN));
      add_row(mk(-ONE, ONE, ONE, ONE, ONE / 2));   // negative mass
      add_row(mk(ONE * 2, ONE, ONE, ONE, ONE / 2));
      add_row(mk(ONE / 2, ONE, -ONE, ONE, ONE / 3));
      add_row(mk(0, ONE, ONE, ONE, ONE / 2));      // zero mass
      add_row(mk(32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1));
      add_row(mk(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
      add_row(mk(ONE * 3, ONE * 4, ONE / 2, ONE * 2, ONE * 2));
      add_row(mk(ONE * 3 / 2, ONE, ONE, ONE, -ONE / 2));

      foreach (dir_rows[i]) begin
         send_event(dir_rows[i].ev);
         if (dir_rows[i].fixed) begin
            a = expected_amps[$];
            if (a.re !== dir_rows[i].amp.re || a.im !== dir_rows[i].amp.im ||
                a.sat !== dir_rows[i].amp.sat) begin
               $error("directed row %0d predictor disagrees with table", i);
               errors++;
            end
            expected_amps[$] = dir_rows[i].amp;
         end
      end
      req_if.valid <= 1'b0;
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_RESONANCE_MASS, 31'h7FFF_FFFF);
               write_reg(REG_RESONANCE_WIDTH, '0);
            end
            1: begin
               write_reg(REG_RESONANCE_MASS, '0);
               write_reg(REG_RESONANCE_WIDTH, 31'h7FFF_FFFF);
            end
            2: begin
               write_reg(REG_RESONANCE_MASS, 31'($urandom));
               write_reg(REG_RESONANCE_WIDTH, 31'($urandom));
            end
            3: begin
               write_reg(REG_RESONANCE_MASS, 31'd25165824);
               write_reg(REG_RESONANCE_WIDTH, 31'd3355443);
            end
            default: begin
               write_reg(REG_RESONANCE_MASS, MASS_RESET);
               write_reg(REG_RESONANCE_WIDTH, WIDTH_RESET);
            end
         endcase
         case (phase)
            0, 1: begin send_idle_pct = 37; recv_idle_pct = 75; end
            2, 3: begin send_idle_pct = 75; recv_idle_pct = 37; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 4) hold_off = 300;  // long receiver stall fills the pipeline
         for (int n = 0; n < 305; n++) begin
            e = rnd_event();
            send_event(e);
         end
         req_if.valid <= 1'b0;
         drain();
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
